// File: src/pbm_to_mono_frame_packer_top_assert.svh
// Assertion macros for the PBM frame packer checker.
// Expects i_clk and i_rst_n in the scope that uses them.
`ifndef PBM_TO_MONO_FRAME_PACKER_TOP_ASSERT_SVH
`define PBM_TO_MONO_FRAME_PACKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define PBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pbm_pkg.sv
// Shared types and constants for the PBM frame packer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pbm_pkg;

    localparam int FRAME_WIDTH  = 400;
    localparam int FRAME_HEIGHT = 300;
    localparam int ROW_BYTES    = FRAME_WIDTH / 8;
    localparam int TOTAL_BYTES  = ROW_BYTES * FRAME_HEIGHT;
    localparam int IDX_W        = $clog2(TOTAL_BYTES + 1);
    localparam int NUM_MAX      = 65535;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);

    localparam logic [7:0] CH_P    = 8'h50;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_1    = 8'h31;
    localparam logic [7:0] CH_4    = 8'h34;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] MSB_BIT = 8'h80;
    localparam logic [7:0] ALL_ONES = 8'hFF;
    localparam logic [4:0] DEC_BASE = 5'd10;

    typedef enum logic [3:0] {
        PH_MAGIC = 4'd0,
        PH_WSKIP = 4'd1,
        PH_WDIG  = 4'd2,
        PH_HSKIP = 4'd3,
        PH_HDIG  = 4'd4,
        PH_DSKIP = 4'd5,
        PH_RAW   = 4'd6,
        PH_DONE  = 4'd7
    } t_phase;

    typedef enum logic [1:0] {
        EV_CLEAR  = 2'd0,
        EV_WRITE  = 2'd1,
        EV_STATUS = 2'd2
    } t_event;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_BAD_NUM   = 3'd2,
        ST_MISMATCH  = 3'd3,
        ST_SHORT     = 3'd4,
        ST_BAD_PIXEL = 3'd5
    } t_status;

    typedef struct packed {
        t_event      kind;
        logic [13:0] addr;
        logic [7:0]  val;
        t_status     st;
    } t_result;

    // All results caused by one input byte; count is 0..3.
    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     res;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

// File: src/pbm_front.sv
// Front end: header and pixel parser, one byte per cycle while the queue is not full, at most one bundle out per byte.
// Depends on pbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbm_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [7:0]      i_file_byte,
    input  wire logic            i_file_end,
    input  wire pbm_pkg::t_qstat i_qstat,
    output logic                 o_push,
    output pbm_pkg::t_bundle     o_bundle
);
    import pbm_pkg::*;

    t_phase             r_phase,   n_phase;
    logic               r_raster,  n_raster;
    logic               r_comment, n_comment;
    logic [15:0]        r_acc,     n_acc;
    logic [15:0]        r_width,   n_width;
    logic [8:0]         r_col,     n_col;
    logic [8:0]         r_row,     n_row;
    logic [IDX_W-1:0]   r_idx,     n_idx;
    logic [7:0]         r_partial, n_partial;
    logic [1:0]         r_seen,    n_seen;
    t_bundle            w_bundle;
    logic               w_accept;

    function automatic logic [15:0] add_digit(input logic [15:0] a, input logic [7:0] c);
        logic [19:0] v;
        v = {4'b0, a} * {15'b0, DEC_BASE} + {16'b0, c[3:0]};
        return (v > 20'(NUM_MAX)) ? 16'(NUM_MAX) : v[15:0];
    endfunction

    // Returns {consumed, new comment flag}.
    function automatic logic [1:0] skip_fn(input logic ic, input logic [7:0] c);
        logic sp;
        sp = (c == CH_SP) || (c == CH_LF) || (c == CH_CR) || (c == CH_TAB);
        if (ic)
            return {1'b1, (c != CH_LF)};
        else if (c == CH_HASH)
            return 2'b11;
        else
            return {sp, 1'b0};
    endfunction

    function automatic t_result mk(input t_event k, input logic [13:0] a,
                                   input logic [7:0] v, input t_status s);
        t_result r;
        r.kind = k;
        r.addr = a;
        r.val  = v;
        r.st   = s;
        return r;
    endfunction

    assign w_accept = i_valid && !i_qstat.full;

    // Next-state and result computation
    always_comb begin
        t_bundle      b;
        logic [1:0]   cnt;
        logic         fin;
        t_status      fin_st;
        logic         do_hs, do_hd, hd_ds, do_ds, do_raw;
        logic [1:0]   sk;
        logic         digit;
        logic [7:0]   c;
        logic [15:0]  addr_full;

        n_phase   = r_phase;
        n_raster  = r_raster;
        n_comment = r_comment;
        n_acc     = r_acc;
        n_width   = r_width;
        n_col     = r_col;
        n_row     = r_row;
        n_idx     = r_idx;
        n_partial = r_partial;
        n_seen    = r_seen;
        b         = '0;
        cnt       = 2'd0;
        fin       = 1'b0;
        fin_st    = ST_OK;
        do_hs     = 1'b0;
        do_hd     = 1'b0;
        hd_ds     = 1'b0;
        do_ds     = 1'b0;
        do_raw    = 1'b0;
        sk        = 2'b00;
        c         = i_file_byte;
        digit     = (c >= CH_0) && (c <= CH_9);
        addr_full = '0;

        case (r_phase)
            PH_MAGIC: begin
                if (r_seen == 2'd0) begin
                    if (c != CH_P) begin
                        fin = 1'b1; fin_st = ST_BAD_MAGIC;
                    end else begin
                        n_seen = 2'd1;
                        if (i_file_end) begin fin = 1'b1; fin_st = ST_BAD_MAGIC; end
                    end
                end else begin
                    if (c != CH_1 && c != CH_4) begin
                        fin = 1'b1; fin_st = ST_BAD_MAGIC;
                    end else begin
                        n_raster  = (c == CH_4);
                        n_seen    = 2'd2;
                        n_phase   = PH_WSKIP;
                        n_comment = 1'b0;
                        if (i_file_end) begin fin = 1'b1; fin_st = ST_BAD_MAGIC; end
                    end
                end
            end
            PH_WSKIP, PH_HSKIP: do_hs = 1'b1;
            PH_WDIG: begin
                if (digit) begin
                    n_acc = add_digit(r_acc, c);
                    if (i_file_end) begin fin = 1'b1; fin_st = ST_BAD_NUM; end
                end else begin
                    n_width   = r_acc;
                    n_acc     = '0;
                    n_comment = 1'b0;
                    n_phase   = PH_HSKIP;
                    do_hs     = 1'b1;
                end
            end
            PH_HDIG: begin
                if (digit) begin
                    n_acc = add_digit(r_acc, c);
                    do_hd = i_file_end;
                end else begin
                    do_hd = 1'b1;
                    hd_ds = 1'b1;
                end
            end
            PH_DSKIP: do_ds  = 1'b1;
            PH_RAW:   do_raw = 1'b1;
            default: ;
        endcase

        if (do_hs) begin
            sk        = skip_fn(n_comment, c);
            n_comment = sk[0];
            if (sk[1]) begin
                if (i_file_end) begin fin = 1'b1; fin_st = ST_BAD_NUM; end
            end else if (!digit) begin
                fin = 1'b1; fin_st = ST_BAD_NUM;
            end else begin
                n_acc = add_digit(16'd0, c);
                if (n_phase == PH_WSKIP) begin
                    n_phase = PH_WDIG;
                    if (i_file_end) begin fin = 1'b1; fin_st = ST_BAD_NUM; end
                end else begin
                    n_phase = PH_HDIG;
                    do_hd   = i_file_end;
                end
            end
        end

        // Height complete: size check, then clear event
        if (do_hd) begin
            if (n_width != 16'(FRAME_WIDTH) || n_acc != 16'(FRAME_HEIGHT)) begin
                fin = 1'b1; fin_st = ST_MISMATCH;
            end else begin
                b.res[cnt] = mk(EV_CLEAR, '0, '0, ST_OK);
                cnt        = cnt + 2'd1;
                n_phase    = PH_DSKIP;
                n_comment  = 1'b0;
                if (hd_ds)
                    do_ds = 1'b1;
                else begin
                    fin = 1'b1; fin_st = n_raster ? ST_BAD_NUM : ST_SHORT;
                end
            end
        end

        if (do_ds) begin
            sk = skip_fn(n_comment, c);
            if (sk[1]) begin
                n_comment = sk[0];
                if (i_file_end) begin
                    fin = 1'b1; fin_st = n_raster ? ST_BAD_NUM : ST_SHORT;
                end
            end else if (n_raster) begin
                n_comment = 1'b0;
                n_phase   = PH_RAW;
                do_raw    = 1'b1;
            end else if (c != CH_0 && c != CH_1) begin
                fin = 1'b1; fin_st = ST_BAD_PIXEL;
            end else begin
                if (c == CH_1)
                    n_partial = n_partial & ~(MSB_BIT >> n_col[2:0]);
                // Byte full, or last pixel of a ragged row
                if (n_col[2:0] == 3'd7 || ({1'b0, n_col} + 10'd1) >= 10'(FRAME_WIDTH)) begin
                    addr_full  = 16'({7'b0, n_row} * 16'(ROW_BYTES)) + {10'b0, n_col[8:3]};
                    b.res[cnt] = mk(EV_WRITE, addr_full[13:0], n_partial, ST_OK);
                    cnt        = cnt + 2'd1;
                    n_partial  = ALL_ONES;
                end
                n_col = n_col + 9'd1;
                if (n_col >= 9'(FRAME_WIDTH)) begin
                    n_col = '0;
                    n_row = n_row + 9'd1;
                    if (n_row >= 9'(FRAME_HEIGHT)) begin
                        fin = 1'b1; fin_st = ST_OK;
                    end else if (i_file_end) begin
                        fin = 1'b1; fin_st = ST_SHORT;
                    end
                end else if (i_file_end) begin
                    fin = 1'b1; fin_st = ST_SHORT;
                end
            end
        end

        if (do_raw) begin
            if (i_file_end && ({1'b0, n_idx} + 1'b1) < (IDX_W + 1)'(TOTAL_BYTES)) begin
                // Partial raw frame is thrown away by a second clear
                if (n_idx != '0) begin
                    b.res[cnt] = mk(EV_CLEAR, '0, '0, ST_OK);
                    cnt        = cnt + 2'd1;
                end
                fin = 1'b1; fin_st = ST_SHORT;
            end else begin
                b.res[cnt] = mk(EV_WRITE, 14'(n_idx), c, ST_OK);
                cnt        = cnt + 2'd1;
                n_idx      = n_idx + 1'b1;
                if (n_idx >= IDX_W'(TOTAL_BYTES)) begin fin = 1'b1; fin_st = ST_OK; end
            end
        end

        if (fin) begin
            b.res[cnt] = mk(EV_STATUS, '0, '0, fin_st);
            cnt        = cnt + 2'd1;
            n_phase    = PH_DONE;
        end
        b.count = cnt;

        if (i_file_end) begin
            n_phase   = PH_MAGIC;
            n_raster  = 1'b0;
            n_comment = 1'b0;
            n_acc     = '0;
            n_width   = '0;
            n_col     = '0;
            n_row     = '0;
            n_idx     = '0;
            n_partial = ALL_ONES;
            n_seen    = 2'd0;
        end

        w_bundle = b;
    end

    // Outputs
    always_comb begin
        o_stall  = i_qstat.full;
        o_push   = w_accept && (w_bundle.count != 2'd0);
        o_bundle = w_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_MAGIC;
            r_raster  <= 1'b0;
            r_comment <= 1'b0;
            r_acc     <= '0;
            r_width   <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_idx     <= '0;
            r_partial <= ALL_ONES;
            r_seen    <= 2'd0;
        end else if (w_accept) begin
            r_phase   <= n_phase;
            r_raster  <= n_raster;
            r_comment <= n_comment;
            r_acc     <= n_acc;
            r_width   <= n_width;
            r_col     <= n_col;
            r_row     <= n_row;
            r_idx     <= n_idx;
            r_partial <= n_partial;
            r_seen    <= n_seen;
        end
    end

endmodule

`default_nettype wire

// File: src/pbm_queue.sv
// Short bundle queue between parser and output serialiser.
// Depends on pbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbm_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire pbm_pkg::t_bundle i_bundle,
    input  wire logic             i_pop,
    output pbm_pkg::t_bundle      o_head,
    output pbm_pkg::t_qstat       o_qstat
);
    import pbm_pkg::*;

    t_bundle           r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QPTR_W:0]   r_count, n_count;

    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = i_pop  ? r_rd + 1'b1 : r_rd;
        n_count = r_count + {{QPTR_W{1'b0}}, i_push} - {{QPTR_W{1'b0}}, i_pop};
    end

    assign o_head        = r_mem[r_rd];
    assign o_qstat.full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push)
            r_mem[r_wr] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: src/pbm_back.sv
// Back end: splits queued bundles into single results behind an output register.
// Depends on pbm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pbm_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire pbm_pkg::t_bundle i_head,
    input  wire pbm_pkg::t_qstat  i_qstat,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic [1:0]            o_event_kind,
    output logic [13:0]           o_byte_address,
    output logic [7:0]            o_byte_value,
    output logic [2:0]            o_status_code,
    output logic                  o_run_end
);
    import pbm_pkg::*;

    logic        r_valid, n_valid;
    logic [1:0]  r_sel,   n_sel;
    t_result     r_res;
    logic        r_last;
    logic        w_load;
    logic        w_pop;

    always_comb begin
        // Output register free, or its transaction completes now
        w_load  = !i_qstat.empty && (!r_valid || !i_stall);
        w_pop   = w_load && (r_sel == i_head.count - 2'd1);
        n_sel   = w_load ? (w_pop ? 2'd0 : r_sel + 2'd1) : r_sel;
        n_valid = w_load || (r_valid && i_stall);
    end

    assign o_pop          = w_pop;
    assign o_valid        = r_valid;
    assign o_event_kind   = r_res.kind;
    assign o_byte_address = r_res.addr;
    assign o_byte_value   = r_res.val;
    assign o_status_code  = r_res.st;
    assign o_run_end      = r_last;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res  <= i_head.res[r_sel];
            r_last <= w_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

endmodule

`default_nettype wire

// File: src/pbm_to_mono_frame_packer_top.sv
// Top level of the PBM (P1/P4) to mono frame packer.
// Depends on pbm_pkg, pbm_front, pbm_queue, pbm_back.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+----------------------------------------------
//  input   | i_valid | o_stall | i_file_byte, i_file_end
//  output  | o_valid | i_stall | o_event_kind, o_byte_address, o_byte_value,
//          |         |         | o_status_code, o_run_end
//
// One file byte is taken per cycle while the four-entry bundle queue has room.
// Results leave one per cycle from the output register while i_stall is low; the
// up to three results caused by one byte leave one after another.
// A byte's first result passes through the bundle queue and then the output register.
// Reset is synchronous, active low, and leaves the parser expecting a magic byte.
// o_stall rises only when the queue is full; output stall holds the result.
`timescale 1ns / 1ps
`default_nettype none

module pbm_to_mono_frame_packer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_file_byte,
    input  wire logic        i_file_end,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_event_kind,
    output logic [13:0]      o_byte_address,
    output logic [7:0]       o_byte_value,
    output logic [2:0]       o_status_code,
    output logic             o_run_end
);
    import pbm_pkg::*;

    t_qstat  w_qstat;
    t_bundle w_push_bundle;
    t_bundle w_head;
    logic    w_push;
    logic    w_pop;

    pbm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_file_byte (i_file_byte),
        .i_file_end  (i_file_end),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_bundle    (w_push_bundle)
    );

    pbm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_push_bundle),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_qstat  (w_qstat)
    );

    pbm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (w_head),
        .i_qstat        (w_qstat),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_kind   (o_event_kind),
        .o_byte_address (o_byte_address),
        .o_byte_value   (o_byte_value),
        .o_status_code  (o_status_code),
        .o_run_end      (o_run_end)
    );

endmodule

`default_nettype wire

// File: src/pbm_checker.sv
// Port-level checker for the PBM frame packer, bound to the top level.
// Depends on pbm_pkg and pbm_to_mono_frame_packer_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "pbm_to_mono_frame_packer_top_assert.svh"

module pbm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [1:0]  o_event_kind,
    input wire logic [13:0] o_byte_address,
    input wire logic [7:0]  o_byte_value,
    input wire logic [2:0]  o_status_code,
    input wire logic        o_run_end
);
    import pbm_pkg::*;

    logic [27:0] w_out_fields;
    assign w_out_fields = {o_event_kind, o_byte_address, o_byte_value, o_status_code,
                           o_run_end};

    `PBM_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid, "output transaction dropped under stall")
    `PBM_ASSERT_NEXT(a_out_stable, o_valid && i_stall, $stable(w_out_fields), "stalled result changed")
    `PBM_ASSERT_NOW(a_status_last, o_valid && (o_event_kind == EV_STATUS), o_run_end, "status not last result of its byte")
    `PBM_ASSERT_NOW(a_nonwrite_zero, o_valid && (o_event_kind != EV_WRITE), (o_byte_address == 14'd0) && (o_byte_value == 8'd0), "clear or status carries data")
    // A full queue always has a result waiting in the output register
    `PBM_ASSERT_NOW(a_stall_backlog, o_stall, o_valid, "input stalled with no result waiting")

endmodule

bind pbm_to_mono_frame_packer_top pbm_checker u_pbm_checker (.*);

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for pbm_to_mono_frame_packer_top.
// Needs pbm_pkg and the packer RTL; mirrors the PBM parser and checks every result transaction.

module testbench;

    import pbm_pkg::*;

    localparam int HANG_LIMIT   = 2000;
    localparam int RANDOM_BYTES = 32;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_due;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_file_byte;
    logic        i_file_end;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_event_kind;
    logic [13:0] o_byte_address;
    logic [7:0]  o_byte_value;
    logic [2:0]  o_status_code;
    logic        o_run_end;

    // parser mirror
    t_phase      p_phase;
    logic        p_raster;
    logic        p_in_comment;
    logic [15:0] p_number;
    logic [15:0] p_width;
    logic [8:0]  p_col;
    logic [8:0]  p_row;
    logic [13:0] p_index;
    logic [7:0]  p_partial;
    logic [1:0]  p_magic_cnt;

    t_result     step_events [3];
    int          step_count;
    int unsigned parsed_bytes = 0;
    t_due        frame_events_due [$];
    t_due        due_now;
    logic [7:0]  file_bytes [$];

    int          errors = 0;
    logic        idle_on = 1'b0;
    int          rx_gap = 0;

    pbm_to_mono_frame_packer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_file_byte    (i_file_byte),
        .i_file_end     (i_file_end),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_event_kind   (o_event_kind),
        .o_byte_address (o_byte_address),
        .o_byte_value   (o_byte_value),
        .o_status_code  (o_status_code),
        .o_run_end      (o_run_end)
    );

    always #5 i_clk = ~i_clk;

    function automatic void start_of_file();
        p_phase      = PH_MAGIC;
        p_raster     = 1'b0;
        p_in_comment = 1'b0;
        p_number     = '0;
        p_width      = '0;
        p_col        = '0;
        p_row        = '0;
        p_index      = '0;
        p_partial    = ALL_ONES;
        p_magic_cnt  = '0;
    endfunction

    function automatic void add_event(t_event k, logic [13:0] a, logic [7:0] v, t_status s);
        if (step_count < 3) begin
            step_events[step_count] = '{kind: k, addr: a, val: v, st: s};
            step_count++;
        end
    endfunction

    function automatic void end_with_status(t_status s);
        add_event(EV_STATUS, '0, '0, s);
        p_phase = PH_DONE;
    endfunction

    // Status for a file that stops inside the data preamble.
    function automatic t_status early_end_status();
        if (p_raster)
            return ST_BAD_NUM;
        return ST_SHORT;
    endfunction

    // Whitespace and '#' comments up to a line feed are swallowed.
    function automatic logic skip_filler(logic [7:0] c);
        if (p_in_comment) begin
            if (c == CH_LF)
                p_in_comment = 1'b0;
            return 1'b1;
        end
        if (c == CH_HASH) begin
            p_in_comment = 1'b1;
            return 1'b1;
        end
        return c == CH_SP || c == CH_LF || c == CH_CR || c == CH_TAB;
    endfunction

    function automatic void push_digit(logic [7:0] c);
        int unsigned v;
        v = p_number;
        v = v * 10 + (c - CH_0);
        p_number = (v > NUM_MAX) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic logic size_matches();
        if (p_width != FRAME_WIDTH || p_number != FRAME_HEIGHT) begin
            end_with_status(ST_MISMATCH);
            return 1'b0;
        end
        add_event(EV_CLEAR, '0, '0, ST_OK);
        p_phase      = PH_DSKIP;
        p_in_comment = 1'b0;
        return 1'b1;
    endfunction

    function automatic void take_raw(logic [7:0] c, logic e);
        if (e && p_index + 1 < TOTAL_BYTES) begin
            // partial raster is thrown away by a second clear
            if (p_index > 0)
                add_event(EV_CLEAR, '0, '0, ST_OK);
            end_with_status(ST_SHORT);
            return;
        end
        add_event(EV_WRITE, p_index, c, ST_OK);
        p_index = p_index + 1;
        if (p_index >= TOTAL_BYTES)
            end_with_status(ST_OK);
    endfunction

    function automatic void take_data(logic [7:0] c, logic e);
        if (skip_filler(c)) begin
            if (e)
                end_with_status(early_end_status());
            return;
        end
        if (p_raster) begin
            p_in_comment = 1'b0;
            p_phase      = PH_RAW;
            take_raw(c, e);
            return;
        end
        if (c != CH_0 && c != CH_1) begin
            end_with_status(ST_BAD_PIXEL);
            return;
        end
        if (c == CH_1)
            p_partial = p_partial & ~(MSB_BIT >> p_col[2:0]);
        if (p_col[2:0] == 3'd7 || p_col + 1 >= FRAME_WIDTH) begin
            add_event(EV_WRITE, 14'(p_row * ROW_BYTES + (p_col >> 3)), p_partial, ST_OK);
            p_partial = ALL_ONES;
        end
        p_col = p_col + 1'b1;
        if (p_col >= FRAME_WIDTH) begin
            p_col = '0;
            p_row = p_row + 1'b1;
            if (p_row >= FRAME_HEIGHT) begin
                end_with_status(ST_OK);
                return;
            end
        end
        if (e)
            end_with_status(ST_SHORT);
    endfunction

    function automatic void take_header(logic [7:0] c, logic e);
        if (skip_filler(c)) begin
            if (e)
                end_with_status(ST_BAD_NUM);
            return;
        end
        if (c < CH_0 || c > CH_9) begin
            end_with_status(ST_BAD_NUM);
            return;
        end
        p_number = '0;
        push_digit(c);
        if (p_phase == PH_WSKIP) begin
            p_phase = PH_WDIG;
            if (e)
                end_with_status(ST_BAD_NUM);
        end else begin
            p_phase = PH_HDIG;
            if (e) begin
                if (size_matches())
                    end_with_status(early_end_status());
            end
        end
    endfunction

    // Works out the results one accepted file byte causes and queues them.
    function automatic void take_file_byte(logic [7:0] c, logic e);
        logic digit;
        digit = c >= CH_0 && c <= CH_9;
        step_count = 0;
        if (p_phase != PH_DONE)
            parsed_bytes++;
        case (p_phase)
            PH_MAGIC: begin
                if (p_magic_cnt == 0) begin
                    if (c != CH_P) begin
                        end_with_status(ST_BAD_MAGIC);
                    end else begin
                        p_magic_cnt = 2'd1;
                        if (e)
                            end_with_status(ST_BAD_MAGIC);
                    end
                end else if (c != CH_1 && c != CH_4) begin
                    end_with_status(ST_BAD_MAGIC);
                end else begin
                    p_raster     = (c == CH_4);
                    p_magic_cnt  = 2'd2;
                    p_phase      = PH_WSKIP;
                    p_in_comment = 1'b0;
                    if (e)
                        end_with_status(ST_BAD_MAGIC);
                end
            end
            PH_WSKIP, PH_HSKIP: take_header(c, e);
            PH_WDIG: begin
                if (digit) begin
                    push_digit(c);
                    if (e)
                        end_with_status(ST_BAD_NUM);
                end else begin
                    p_width      = p_number;
                    p_number     = '0;
                    p_in_comment = 1'b0;
                    p_phase      = PH_HSKIP;
                    take_header(c, e);
                end
            end
            PH_HDIG: begin
                if (digit) begin
                    push_digit(c);
                    if (e) begin
                        if (size_matches())
                            end_with_status(early_end_status());
                    end
                end else if (size_matches()) begin
                    take_data(c, e);
                end
            end
            PH_DSKIP: take_data(c, e);
            PH_RAW:   take_raw(c, e);
            default: ;
        endcase
        for (int k = 0; k < step_count; k++)
            frame_events_due.push_back('{res: step_events[k], last: (k == step_count - 1)});
        if (e)
            start_of_file();
    endfunction

    // ---- stimulus helpers ----

    task automatic send_byte(input logic [7:0] b, input logic e);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_file_byte = b;
        i_file_end  = e;
        do
            @(posedge i_clk);
        while (o_stall);
        take_file_byte(b, e);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic transmit_file();
        foreach (file_bytes[i])
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            file_bytes.push_back(s[i]);
    endfunction

    task automatic send_text_file(string s);
        add_text(s);
        transmit_file();
    endtask

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SP;
            1:       return CH_LF;
            2:       return CH_CR;
            default: return CH_TAB;
        endcase
    endfunction

    function automatic void add_comment();
        logic [7:0] b;
        file_bytes.push_back(CH_HASH);
        repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            file_bytes.push_back(b == CH_LF ? CH_SP : b);
        end
        file_bytes.push_back(CH_LF);
    endfunction

    function automatic void add_gap();
        repeat ($urandom_range(1, 3))
            file_bytes.push_back(random_blank());
        if ($urandom_range(0, 4) == 0)
            add_comment();
    endfunction

    function automatic void add_number(int unsigned v);
        if ($urandom_range(0, 5) == 0)
            file_bytes.push_back(CH_0);
        add_text($sformatf("%0d", v));
    endfunction

    // Mostly well-formed headers with a little random content; some noise, bad headers and cut files.
    task automatic send_random_file();
        int   shape;
        int   n;
        logic p4;
        int   pick;
        shape = $urandom_range(0, 9);
        p4    = $urandom_range(0, 1);
        if (shape == 0) begin
            if ($urandom_range(0, 1))
                file_bytes.push_back(CH_P);
            repeat ($urandom_range(1, 6))
                file_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            file_bytes.push_back(CH_P);
            file_bytes.push_back(p4 ? CH_4 : CH_1);
            if ($urandom_range(0, 3) != 0)
                add_gap();
            add_number(shape == 1 ? $urandom_range(0, 99999) : FRAME_WIDTH);
            if (shape == 3)
                file_bytes.push_back(8'($urandom_range(0, 255)));
            else
                add_gap();
            add_number(shape == 2 ? $urandom_range(0, 99999) : FRAME_HEIGHT);
            if ($urandom_range(0, 5) != 0)
                add_gap();
            n = $urandom_range(0, 24);
            repeat (n) begin
                if (p4) begin
                    file_bytes.push_back(8'($urandom_range(0, 255)));
                end else begin
                    pick = $urandom_range(0, 24);
                    if (pick < 20)
                        file_bytes.push_back($urandom_range(0, 1) ? CH_1 : CH_0);
                    else if (pick < 23)
                        file_bytes.push_back(random_blank());
                    else if (pick == 23)
                        add_comment();
                    else
                        file_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > n)
                void'(file_bytes.pop_back());
        end
        transmit_file();
    endtask

    // ---- tests ----

    task automatic test_magic_word();
        send_text_file("P");
        send_text_file("Q");
        send_text_file("Qjunk");
        send_text_file("P1");
        send_text_file("P7 400 300");
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'hFF);
        transmit_file();
    endtask

    task automatic test_header_fields();
        send_text_file("P1 400");
        send_text_file("P4 ");
        send_text_file("P1 x");
        send_text_file("P4 400 y");
        send_text_file("P1 399 300 1");
        send_text_file("P4 400 299\n");
        send_text_file("P1 99999999 300 ");
        send_text_file("P1 400 99999999 ");
        send_text_file("P1400 0300 #c\n0");
        send_text_file("P4 400 300");
        send_text_file("P1 400 300");
        add_text("P1\t# note\n400\n300");
        file_bytes.push_back(CH_CR);
        file_bytes.push_back(CH_LF);
        transmit_file();
        send_text_file("P4 400 300 #c");
        send_text_file("P4 400 300A12");
    endtask

    task automatic test_raw_short();
        send_text_file("P4 400 300\nZ");
        add_text("P4\n#c\n400 300\n#x\n\n");
        repeat (10)
            file_bytes.push_back(8'($urandom_range(0, 255)));
        transmit_file();
    endtask

    task automatic test_plain_pixels();
        send_text_file("P1 400 300\n1010 0101 #c\n 111100002xyz");
        send_text_file("P1 400 300\n1111000011110000 ");
        send_text_file("P1 400 300\n101");
    endtask

    task automatic test_random_files();
        int unsigned first;
        first = parsed_bytes;
        while (parsed_bytes - first < RANDOM_BYTES) begin
            idle_on = $urandom_range(0, 4) != 0;
            send_random_file();
        end
    endtask

    // ---- result side ----

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_gap != 0) begin
                i_stall = 1'b1;
                rx_gap--;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                i_stall = 1'b1;
                rx_gap  = $urandom_range(0, 11);
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (frame_events_due.size() == 0) begin
                $error("result transaction with nothing expected (kind %0d)", o_event_kind);
                errors++;
            end else begin
                due_now = frame_events_due.pop_front();
                compare_field("event_kind", 16'(due_now.res.kind), 16'(o_event_kind));
                compare_field("byte_address", 16'(due_now.res.addr), 16'(o_byte_address));
                compare_field("byte_value", 16'(due_now.res.val), 16'(o_byte_value));
                compare_field("status_code", 16'(due_now.res.st), 16'(o_status_code));
                compare_field("run_end", 16'(due_now.last), 16'(o_run_end));
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transaction for %0d cycles", HANG_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_file_byte = '0;
        i_file_end  = 1'b0;
        start_of_file();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        idle_on = 1'b1;
        test_magic_word();
        test_header_fields();
        test_raw_short();
        test_random_files();
        // closing stretch adds no new idle gaps on either side
        idle_on = 1'b0;
        test_plain_pixels();

        while (frame_events_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
